// ===== sv/brfr_pkg.sv =====
// Package for the byte ring FIFO with rewind: sizes, command and status codes,
// and the item, memory request and result-info structs.
// No dependencies.
package brfr_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_PUSH  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_SHIFT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NO_DATA = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] in_byte;
    } req_item_t;

    typedef struct packed {
        logic [7:0] read_byte;
        status_t    status;
        logic [8:0] fill_count;
    } rsp_item_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } ram_req_t;

    typedef struct packed {
        logic       rd_ok;
        status_t    status;
        logic [8:0] fill_count;
    } rsp_info_t;

endpackage

// ===== sv/byte_ring_fifo_with_rewind_unit.sv =====
// Top level of the byte ring FIFO with rewind.
// Uses brfr_pkg, brfr_ctrl and brfr_ram.

// Every item (clear, push, read, shift) gives one result. An item is taken at
// the edge where req_valid and req_ready are high; its result passes stage p,
// which waits on the registered read of the single-port byte RAM, then the
// output register on rsp. One item per cycle is sustained while rsp_ready
// stays high; the RAM port, used once per item, sets that figure. The byte
// store needs no clearing pass after reset: only pushed bytes are read back.
module byte_ring_fifo_with_rewind_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  brfr_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output brfr_pkg::rsp_item_t rsp
);

    brfr_pkg::ram_req_t  ram_req;
    brfr_pkg::rsp_info_t info;
    logic [7:0]          ram_rdata;
    logic                go;
    logic                advance;

    logic                p_valid_reg, p_valid_next;
    brfr_pkg::rsp_info_t p_info_reg;
    logic                out_valid_reg, out_valid_next;
    brfr_pkg::rsp_item_t out_reg;

    // Stage p waits for RAM data; it holds (and no new read is issued)
    // while the output register is full and stalled.
    assign advance   = p_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !p_valid_reg || !out_valid_reg || rsp_ready;
    assign go        = req_valid && req_ready;

    assign p_valid_next   = go || (p_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !rsp_ready);

    brfr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .item    (req),
        .ram_req (ram_req),
        .info    (info)
    );

    brfr_ram #(
        .WIDTH (8),
        .DEPTH (brfr_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (go && ram_req.we),
        .re    (go && ram_req.re),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            p_info_reg <= info;
        end
        if (advance)
        begin
            out_reg.read_byte  <= p_info_reg.rd_ok ? ram_rdata : 8'd0;
            out_reg.status     <= p_info_reg.status;
            out_reg.fill_count <= p_info_reg.fill_count;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        go |=> p_valid_reg)
        else $error("accepted item not staged");

    assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg && !advance |=> p_valid_reg && $stable(p_info_reg) && $stable(ram_rdata))
        else $error("stalled stage lost its data");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid)
        else $error("staged item did not reach output");

endmodule

// ===== sv/brfr_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module brfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/brfr_ctrl.sv =====
// Pointer control for the byte ring: head, fill count and read cursor.
// Decodes each accepted item into a RAM access and result info. Uses brfr_pkg.
module brfr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  brfr_pkg::req_item_t item,
    output brfr_pkg::ram_req_t  ram_req,
    output brfr_pkg::rsp_info_t info
);

    logic [brfr_pkg::ADDR_W-1:0] head_reg, head_next;
    logic [brfr_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [brfr_pkg::CNT_W-1:0]  offset_reg, offset_next;

    // (head + off) mod DEPTH, off never above DEPTH
    function automatic logic [brfr_pkg::ADDR_W-1:0] ring_pos(
        input logic [brfr_pkg::ADDR_W-1:0] head,
        input logic [brfr_pkg::CNT_W-1:0]  off
    );
        logic [brfr_pkg::SUM_W-1:0] s;
        s = brfr_pkg::SUM_W'(head) + brfr_pkg::SUM_W'(off);
        if (s >= brfr_pkg::SUM_W'(brfr_pkg::DEPTH))
        begin
            s = s - brfr_pkg::SUM_W'(brfr_pkg::DEPTH);
        end
        return s[brfr_pkg::ADDR_W-1:0];
    endfunction

    always_comb
    begin
        head_next     = head_reg;
        count_next    = count_reg;
        offset_next   = offset_reg;
        ram_req       = '0;
        info.rd_ok    = 1'b0;
        info.status   = brfr_pkg::ST_OK;
        case (item.cmd)
            brfr_pkg::CMD_CLEAR:
            begin
                head_next   = '0;
                count_next  = '0;
                offset_next = '0;
            end
            brfr_pkg::CMD_PUSH:
            begin
                if (count_reg >= brfr_pkg::CNT_W'(brfr_pkg::DEPTH))
                begin
                    info.status = brfr_pkg::ST_FULL;
                end
                else
                begin
                    ram_req.we    = 1'b1;
                    ram_req.addr  = ring_pos(head_reg, count_reg);
                    ram_req.wdata = item.in_byte;
                    count_next    = count_reg + 1'b1;
                end
            end
            brfr_pkg::CMD_READ:
            begin
                if (offset_reg >= count_reg)
                begin
                    info.status = brfr_pkg::ST_NO_DATA;
                end
                else
                begin
                    ram_req.re  = 1'b1;
                    ram_req.addr = ring_pos(head_reg, offset_reg);
                    offset_next = offset_reg + 1'b1;
                    info.rd_ok  = 1'b1;
                end
            end
            brfr_pkg::CMD_SHIFT:
            begin
                if (count_reg != '0)
                begin
                    head_next   = (head_reg == brfr_pkg::ADDR_W'(brfr_pkg::DEPTH - 1))
                                  ? '0 : head_reg + 1'b1;
                    count_next  = count_reg - 1'b1;
                    offset_next = '0;
                end
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
        info.fill_count = 9'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            offset_reg <= '0;
        end
        else if (go)
        begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            offset_reg <= offset_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= brfr_pkg::CNT_W'(brfr_pkg::DEPTH))
        else $error("fill count above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg <= count_reg)
        else $error("read cursor past held bytes");

    assert property (@(posedge clk) disable iff (!rst_n)
        go && item.cmd == brfr_pkg::CMD_CLEAR |=> count_reg == '0 && offset_reg == '0)
        else $error("clear did not empty the ring");

    assert property (@(posedge clk) disable iff (!rst_n)
        go && item.cmd == brfr_pkg::CMD_SHIFT && count_reg != '0 |=> offset_reg == '0)
        else $error("shift did not rewind the cursor");

endmodule
